FILE: rtl/core/mlfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfr_pkg
// Shared widths, phase and status codes, and state/result types for the
// meter link frame receiver.
// ----------------------------------------------------------------------------
package mlfr_pkg;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 14;
    localparam int POS_W   = 15;
    localparam int STAT_W  = 4;
    localparam int PHASE_W = 4;

    // channel numbers are compared modulo the channel count
    localparam int CHANNEL_COUNT = 8;
    localparam int CH_W          = 3;

    // frame constants
    localparam logic [BYTE_W-1:0] START_BYTE      = 8'h68;
    localparam logic [BYTE_W-1:0] END_BYTE        = 8'h16;
    localparam logic [LEN_W-1:0]  MIN_LENGTH      = 14'd8;
    localparam logic [LEN_W-1:0]  MAX_LENGTH_RST  = 14'd1016;
    localparam logic [POS_W-1:0]  HEADER_LAST_POS = 15'd13;
    localparam logic [POS_W-1:0]  DATA_BASE       = 15'd5;

    // receive phases
    localparam logic [PHASE_W-1:0] PH_HUNT    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_LEN1_LO = 4'd1;
    localparam logic [PHASE_W-1:0] PH_LEN1_HI = 4'd2;
    localparam logic [PHASE_W-1:0] PH_LEN2_LO = 4'd3;
    localparam logic [PHASE_W-1:0] PH_LEN2_HI = 4'd4;
    localparam logic [PHASE_W-1:0] PH_START2  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_CONTROL = 4'd6;
    localparam logic [PHASE_W-1:0] PH_ADDRESS = 4'd7;
    localparam logic [PHASE_W-1:0] PH_DATA    = 4'd8;
    localparam logic [PHASE_W-1:0] PH_CHECK   = 4'd9;
    localparam logic [PHASE_W-1:0] PH_END     = 4'd10;

    // per-byte status codes
    localparam logic [STAT_W-1:0] ST_IGNORED  = 4'd0;
    localparam logic [STAT_W-1:0] ST_BYTE     = 4'd1;
    localparam logic [STAT_W-1:0] ST_DONE     = 4'd2;
    localparam logic [STAT_W-1:0] ST_LONG     = 4'd3;
    localparam logic [STAT_W-1:0] ST_SHORT    = 4'd4;
    localparam logic [STAT_W-1:0] ST_MISMATCH = 4'd5;
    localparam logic [STAT_W-1:0] ST_START2   = 4'd6;
    localparam logic [STAT_W-1:0] ST_CHECK    = 4'd7;
    localparam logic [STAT_W-1:0] ST_END      = 4'd8;

    // frame tracking state
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [POS_W-1:0]   byte_position;
        logic [LEN_W-1:0]   user_length;
        logic [LEN_W-1:0]   confirm_length;
        logic [BYTE_W-1:0]  running_sum;
        logic [CH_W-1:0]    last_channel;
    } mlfr_state_t;

    // one result beat
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [POS_W-1:0]  position;
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  frame_length;
    } mlfr_result_t;

endpackage
`default_nettype wire

FILE: rtl/core/mlfr_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfr_in_if / mlfr_out_if
// Valid/ready channels carrying received bytes in and per-byte results out.
// ----------------------------------------------------------------------------
interface mlfr_in_if;
    import mlfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic [CH_W-1:0]   channel;

    modport source (output valid, output data_byte, output channel, input ready);
    modport sink   (input valid, input data_byte, input channel, output ready);
endinterface

interface mlfr_out_if;
    import mlfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic [POS_W-1:0]  position;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  frame_length;

    modport source (output valid, output out_byte, output position, output status,
                    output frame_length, input ready);
    modport sink   (input valid, input out_byte, input position, input status,
                    input frame_length, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/mlfr_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfr_step
// Next-state and result logic for one received byte of the frame tracker.
// ----------------------------------------------------------------------------
module mlfr_step
    import mlfr_pkg::*;
(
    input  mlfr_state_t       cur,
    input  logic [LEN_W-1:0]  max_length,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [CH_W-1:0]   channel,
    output mlfr_state_t       nxt,
    output mlfr_result_t      res
);

    logic [LEN_W-1:0]  len_lo;
    logic [LEN_W-1:0]  len1_sum;
    logic [LEN_W-1:0]  len2_sum;
    logic [BYTE_W-1:0] sum_add;
    logic [POS_W-1:0]  end_pos;
    logic [POS_W-1:0]  pos_inc;
    logic              ch_change;

    // datapath pieces
    assign len_lo    = {8'd0, data_byte[7:2]};
    assign len1_sum  = cur.user_length + {data_byte, 6'd0};
    assign len2_sum  = cur.confirm_length + {data_byte, 6'd0};
    assign sum_add   = cur.running_sum + data_byte;
    assign end_pos   = DATA_BASE + {1'b0, cur.user_length};
    assign pos_inc   = cur.byte_position + 15'd1;
    assign ch_change = (channel != cur.last_channel);

    // phase sequencing
    always_comb
    begin
        nxt                   = cur;
        res.out_byte          = data_byte;
        res.position          = cur.byte_position;
        res.status            = ST_BYTE;
        res.frame_length      = '0;
        nxt.phase             = ch_change ? PH_HUNT : cur.phase;
        nxt.last_channel      = channel;

        unique case (nxt.phase)
            PH_HUNT:
            begin
                res.position = '0;
                if (data_byte == START_BYTE)
                begin
                    nxt.user_length = '0;
                    nxt.phase       = PH_LEN1_LO;
                end
                else
                begin
                    res.status = ST_IGNORED;
                end
            end
            PH_LEN1_LO:
            begin
                nxt.user_length = len_lo;
                nxt.phase       = PH_LEN1_HI;
            end
            PH_LEN1_HI:
            begin
                nxt.user_length = len1_sum;
                if (len1_sum < MIN_LENGTH)
                begin
                    res.status = ST_SHORT;
                    nxt.phase  = PH_HUNT;
                end
                else if (len1_sum > max_length)
                begin
                    res.status = ST_LONG;
                    nxt.phase  = PH_HUNT;
                end
                else
                begin
                    nxt.phase = PH_LEN2_LO;
                end
            end
            PH_LEN2_LO:
            begin
                nxt.confirm_length = len_lo;
                nxt.phase          = PH_LEN2_HI;
            end
            PH_LEN2_HI:
            begin
                nxt.confirm_length = len2_sum;
                if (len2_sum == cur.user_length)
                begin
                    nxt.phase = PH_START2;
                end
                else
                begin
                    res.status = ST_MISMATCH;
                    nxt.phase  = PH_HUNT;
                end
            end
            PH_START2:
            begin
                if (data_byte == START_BYTE)
                begin
                    nxt.phase = PH_CONTROL;
                end
                else
                begin
                    res.status = ST_START2;
                    nxt.phase  = PH_HUNT;
                end
            end
            PH_CONTROL:
            begin
                nxt.running_sum = data_byte;
                nxt.phase       = PH_ADDRESS;
            end
            PH_ADDRESS:
            begin
                nxt.running_sum = sum_add;
                // short header: user data may end inside the address field
                if (cur.byte_position == end_pos)
                    nxt.phase = PH_CHECK;
                else if (cur.byte_position == HEADER_LAST_POS)
                    nxt.phase = PH_DATA;
            end
            PH_DATA:
            begin
                nxt.running_sum = sum_add;
                if (cur.byte_position == end_pos)
                    nxt.phase = PH_CHECK;
            end
            PH_CHECK:
            begin
                if (data_byte == cur.running_sum)
                begin
                    nxt.phase = PH_END;
                end
                else
                begin
                    res.status = ST_CHECK;
                    nxt.phase  = PH_HUNT;
                end
            end
            PH_END:
            begin
                if (data_byte == END_BYTE)
                begin
                    res.status       = ST_DONE;
                    res.frame_length = pos_inc;
                end
                else
                begin
                    res.status = ST_END;
                end
                nxt.phase = PH_HUNT;
            end
            default:
            begin
                res.status   = ST_IGNORED;
                res.position = '0;
                nxt.phase    = PH_HUNT;
            end
        endcase

        // position advances on frame bytes, clears on completion
        if (res.status == ST_BYTE)
            nxt.byte_position = res.position + 15'd1;
        if (res.status == ST_DONE)
        begin
            nxt.byte_position = '0;
            nxt.user_length   = '0;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/meter_link_frame_receiver_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// meter_link_frame_receiver_unit
// Byte-wise link frame tracker: 68h L L 68h control address data cs 16h.
// ----------------------------------------------------------------------------
// Usage
//   link   : valid/ready input, one received byte and its channel per beat
//   result : valid/ready output, one beat per input byte with the byte echo,
//            its frame position, a status code and, on completion, the
//            total frame length
//   cfg_wr_en / cfg_wr_data : writes max_length; write only while idle
// Flow: an accepted byte is loaded into the input register, and its result
//   is then registered in the result register and presented as a beat.
// Throughput: one byte per cycle while result beats are taken; the whole
//   per-byte update is a single pass of logic between the input register
//   and the result register.
// Reset: tracker hunts for 68h on channel 0, max_length is 1016, both
//   pipeline registers are empty.
// Stall: with result.ready low the result register holds its beat, the
//   input register takes one more byte, then link.ready drops until the
//   result beat is taken.
// ----------------------------------------------------------------------------
module meter_link_frame_receiver_unit
    import mlfr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    mlfr_in_if.sink          link,
    mlfr_out_if.source       result,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic [CH_W-1:0]   in_chan_reg;
    mlfr_state_t       state_reg;
    mlfr_state_t       state_next;
    mlfr_result_t      res_next;
    mlfr_result_t      res_reg;
    logic              res_valid_reg;
    logic [LEN_W-1:0]  max_length_reg;
    logic              fire;

    // advance when the input register holds a beat and the result slot frees
    assign fire       = in_valid_reg && (!res_valid_reg || result.ready);
    assign link.ready = !in_valid_reg || fire;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_length_reg <= MAX_LENGTH_RST;
        else if (cfg_wr_en)
            max_length_reg <= cfg_wr_data;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (link.ready)
            in_valid_reg <= link.valid;
    end

    always_ff @(posedge clk)
    begin
        if (link.ready && link.valid)
        begin
            in_byte_reg <= link.data_byte;
            in_chan_reg <= link.channel;
        end
    end

    // per-byte frame logic
    mlfr_step u_step (
        .cur        (state_reg),
        .max_length (max_length_reg),
        .data_byte  (in_byte_reg),
        .channel    (in_chan_reg),
        .nxt        (state_next),
        .res        (res_next)
    );

    // tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase          <= PH_HUNT;
            state_reg.byte_position  <= '0;
            state_reg.user_length    <= '0;
            state_reg.confirm_length <= '0;
            state_reg.running_sum    <= '0;
            state_reg.last_channel   <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (fire)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= res_next;
    end

    assign result.valid        = res_valid_reg;
    assign result.out_byte     = res_reg.out_byte;
    assign result.position     = res_reg.position;
    assign result.status       = res_reg.status;
    assign result.frame_length = res_reg.frame_length;

    // checks
    a_done_len: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.status == ST_DONE)
            |-> (res_reg.frame_length == res_reg.position + 15'd1))
        else $error("frame length does not follow end position");

    a_len_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.status != ST_DONE) |-> (res_reg.frame_length == '0))
        else $error("frame length set on a beat that does not complete a frame");

    a_ignored_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.status == ST_IGNORED) |-> (res_reg.position == '0))
        else $error("ignored beat carries a nonzero position");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res_next.status == ST_DONE)
            |=> (state_reg.phase == PH_HUNT && state_reg.byte_position == '0))
        else $error("tracker not back to hunting after a complete frame");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !link.ready |-> (in_valid_reg && res_valid_reg && !result.ready))
        else $error("input stalled while the pipeline could advance");

endmodule
`default_nettype wire

FILE: dv/meter_link_frame_receiver_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_link_frame_receiver_unit_tb
// Drives byte streams into the link frame receiver: mostly well-formed frames
// with random content, plus each kind of broken frame, noise and channel hops.
// A predictor tracks the frame state per accepted byte and the result beats
// are compared field by field, in order, under random idling on both sides
// and across several max_length settings.
// ----------------------------------------------------------------------------
module meter_link_frame_receiver_unit_tb;
    import mlfr_pkg::*;

    // ------------------------------------------------------------------------
    // frame state predictor and in-order result check
    // ------------------------------------------------------------------------
    class frame_tracker;
        logic [LEN_W-1:0]   max_len;
        logic [PHASE_W-1:0] phase;
        logic [POS_W-1:0]   byte_pos;
        logic [LEN_W-1:0]   user_len;
        logic [LEN_W-1:0]   confirm_len;
        logic [BYTE_W-1:0]  data_sum;
        logic [CH_W-1:0]    last_ch;
        mlfr_result_t       expected_q[$];
        int                 error_count;

        function new();
            max_len     = MAX_LENGTH_RST;
            phase       = PH_HUNT;
            byte_pos    = '0;
            user_len    = '0;
            confirm_len = '0;
            data_sum    = '0;
            last_ch     = '0;
            error_count = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // work out the result beat for one accepted byte
        function void note_byte(logic [BYTE_W-1:0] b, logic [CH_W-1:0] ch);
            mlfr_result_t     r;
            logic [POS_W-1:0] pos;
            logic [POS_W-1:0] end_pos;
            logic [CH_W-1:0]  ch_mod;
            r.out_byte     = b;
            r.status       = ST_BYTE;
            r.frame_length = '0;
            end_pos        = DATA_BASE + {1'b0, user_len};
            ch_mod         = CH_W'(ch % CHANNEL_COUNT);
            // a channel change drops any frame in progress
            if (ch_mod != last_ch)
            begin
                last_ch = ch_mod;
                phase   = PH_HUNT;
            end
            pos = byte_pos;
            case (phase)
                PH_HUNT:
                begin
                    pos = '0;
                    if (b == START_BYTE)
                    begin
                        user_len = '0;
                        phase    = PH_LEN1_LO;
                    end
                    else
                        r.status = ST_IGNORED;
                end
                PH_LEN1_LO:
                begin
                    user_len = {8'b0, b[7:2]};
                    phase    = PH_LEN1_HI;
                end
                PH_LEN1_HI:
                begin
                    user_len = user_len + {b, 6'b0};
                    if (user_len < MIN_LENGTH)
                    begin
                        r.status = ST_SHORT;
                        phase    = PH_HUNT;
                    end
                    else if (user_len > max_len)
                    begin
                        r.status = ST_LONG;
                        phase    = PH_HUNT;
                    end
                    else
                        phase = PH_LEN2_LO;
                end
                PH_LEN2_LO:
                begin
                    confirm_len = {8'b0, b[7:2]};
                    phase       = PH_LEN2_HI;
                end
                PH_LEN2_HI:
                begin
                    confirm_len = confirm_len + {b, 6'b0};
                    if (confirm_len == user_len)
                        phase = PH_START2;
                    else
                    begin
                        r.status = ST_MISMATCH;
                        phase    = PH_HUNT;
                    end
                end
                PH_START2:
                begin
                    if (b == START_BYTE)
                        phase = PH_CONTROL;
                    else
                    begin
                        r.status = ST_START2;
                        phase    = PH_HUNT;
                    end
                end
                PH_CONTROL:
                begin
                    data_sum = b;
                    phase    = PH_ADDRESS;
                end
                PH_ADDRESS:
                begin
                    // short frames end user data inside the address field
                    data_sum = data_sum + b;
                    if (pos == end_pos)
                        phase = PH_CHECK;
                    else if (pos == HEADER_LAST_POS)
                        phase = PH_DATA;
                end
                PH_DATA:
                begin
                    data_sum = data_sum + b;
                    if (pos == end_pos)
                        phase = PH_CHECK;
                end
                PH_CHECK:
                begin
                    if (b == data_sum)
                        phase = PH_END;
                    else
                    begin
                        r.status = ST_CHECK;
                        phase    = PH_HUNT;
                    end
                end
                PH_END:
                begin
                    if (b == END_BYTE)
                    begin
                        r.status       = ST_DONE;
                        r.frame_length = pos + 1'b1;
                    end
                    else
                        r.status = ST_END;
                    phase = PH_HUNT;
                end
                default:
                begin
                    r.status = ST_IGNORED;
                    pos      = '0;
                    phase    = PH_HUNT;
                end
            endcase
            if (r.status == ST_BYTE)
                byte_pos = pos + 1'b1;
            if (r.status == ST_DONE)
            begin
                byte_pos = '0;
                user_len = '0;
            end
            r.position = pos;
            expected_q.push_back(r);
        endfunction

        // compare one result beat with the oldest expectation
        function void check_result(mlfr_result_t got);
            mlfr_result_t exp_r;
            if (expected_q.size() == 0)
            begin
                $error("result beat with nothing expected: byte %0d status %0d",
                       got.out_byte, got.status);
                error_count++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.out_byte !== exp_r.out_byte)
            begin
                $error("out_byte: expected %0d, got %0d", exp_r.out_byte, got.out_byte);
                error_count++;
            end
            if (got.position !== exp_r.position)
            begin
                $error("position: expected %0d, got %0d", exp_r.position, got.position);
                error_count++;
            end
            if (got.status !== exp_r.status)
            begin
                $error("status: expected %0d, got %0d", exp_r.status, got.status);
                error_count++;
            end
            if (got.frame_length !== exp_r.frame_length)
            begin
                $error("frame_length: expected %0d, got %0d",
                       exp_r.frame_length, got.frame_length);
                error_count++;
            end
        endfunction
    endclass

    localparam int HOLD_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [LEN_W-1:0] cfg_wr_data;

    mlfr_in_if  link_ch();
    mlfr_out_if result_ch();

    frame_tracker tracker = new();

    logic [BYTE_W-1:0] frame_q[$];
    int items_sent  = 0;
    int burst_left  = 0;
    int cur_max     = MAX_LENGTH_RST;
    bit offering    = 1'b0;
    bit nogap       = 1'b0;
    bit hold_request = 1'b0;

    meter_link_frame_receiver_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .link        (link_ch),
        .result      (result_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // offer one byte, in bursts with random gaps between them
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic [CH_W-1:0] ch);
        int gap;
        if (burst_left == 0)
        begin
            gap = nogap ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                if (offering)
                    link_ch.valid <= 1'b0;
                offering = 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        link_ch.valid     <= 1'b1;
        link_ch.data_byte <= b;
        link_ch.channel   <= ch;
        offering = 1'b1;
        do @(posedge clk); while (!link_ch.ready);
        tracker.note_byte(b, ch);
        items_sent++;
    endtask

    // stop offering and wait for every outstanding result beat
    task automatic drain();
        if (offering)
            link_ch.valid <= 1'b0;
        offering   = 1'b0;
        burst_left = 0;
        while (tracker.pending() != 0) @(posedge clk);
    endtask

    task automatic write_max_length(input int value);
        drain();
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= LEN_W'(value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.max_len = LEN_W'(value);
        cur_max = value;
    endtask

    // one copy of a length word: low six bits high in the first byte
    task automatic push_len(input logic [LEN_W-1:0] v);
        logic [1:0] pad;
        pad = 2'($urandom_range(0, 3));
        frame_q.push_back({v[5:0], pad});
        frame_q.push_back(v[13:6]);
    endtask

    task automatic build_frame(input int len);
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] sum;
        frame_q.delete();
        frame_q.push_back(START_BYTE);
        push_len(LEN_W'(len));
        push_len(LEN_W'(len));
        frame_q.push_back(START_BYTE);
        sum = '0;
        repeat (len)
        begin
            case ($urandom_range(0, 15))
                0:       b = START_BYTE;
                1:       b = END_BYTE;
                default: b = BYTE_W'($urandom_range(0, 255));
            endcase
            frame_q.push_back(b);
            sum = sum + b;
        end
        frame_q.push_back(sum);
        frame_q.push_back(END_BYTE);
    endtask

    function automatic logic [BYTE_W-1:0] other_than(logic [BYTE_W-1:0] x);
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom_range(0, 255)); while (b == x);
        return b;
    endfunction

    // send the queued bytes; one optional byte goes out on another channel
    task automatic send_frame(input logic [CH_W-1:0] ch, input int hop);
        logic [CH_W-1:0] hop_ch;
        hop_ch = ch ^ CH_W'($urandom_range(1, 7));
        foreach (frame_q[i])
            send_byte(frame_q[i], (i == hop) ? hop_ch : ch);
    endtask

    // user-data length, mostly short with the odd long one
    function automatic int pick_length();
        int sel;
        int hi;
        sel = $urandom_range(0, 9);
        hi  = (sel < 7) ? 24 : (sel < 9) ? 120 : 400;
        if (hi > cur_max)
            hi = cur_max;
        return $urandom_range(8, hi);
    endfunction

    task automatic random_frame();
        int kind;
        int len;
        int hop;
        int k;
        logic [CH_W-1:0]  ch;
        logic [LEN_W-1:0] bad;
        ch   = CH_W'($urandom_range(0, 7));
        hop  = -1;
        kind = $urandom_range(0, 99);
        len  = pick_length();
        build_frame(len);
        if (kind < 55)
            ;
        else if (kind < 60)
            hop = $urandom_range(1, frame_q.size() - 1);
        else if (kind < 66 || (kind < 72 && cur_max == 16383))
        begin
            // too short
            frame_q.delete();
            frame_q.push_back(START_BYTE);
            push_len(LEN_W'($urandom_range(0, 7)));
        end
        else if (kind < 72)
        begin
            // too long, often just over the limit
            frame_q.delete();
            frame_q.push_back(START_BYTE);
            if ($urandom_range(0, 1))
                push_len(LEN_W'($urandom_range(cur_max + 1,
                                (cur_max + 40 > 16383) ? 16383 : cur_max + 40)));
            else
                push_len(LEN_W'($urandom_range(cur_max + 1, 16383)));
        end
        else if (kind < 78)
        begin
            // second length copy disagrees in one bit
            k   = $urandom_range(0, 13);
            bad = LEN_W'(len ^ (1 << k));
            frame_q[3] = {bad[5:0], frame_q[3][1:0]};
            frame_q[4] = bad[13:6];
            frame_q    = frame_q[0:4];
        end
        else if (kind < 84)
        begin
            frame_q[5] = other_than(START_BYTE);
            frame_q    = frame_q[0:5];
        end
        else if (kind < 90)
            frame_q[6 + len] = frame_q[6 + len] ^ BYTE_W'($urandom_range(1, 255));
        else if (kind < 95)
            frame_q[7 + len] = other_than(END_BYTE);
        else
        begin
            // line noise
            frame_q.delete();
            repeat ($urandom_range(1, 6))
                frame_q.push_back(other_than(START_BYTE));
        end
        send_frame(ch, hop);
    endtask

    task automatic run_random(input int n_items);
        int first;
        first = items_sent;
        while (items_sent - first < n_items)
            random_frame();
    endtask

    // ------------------------------------------------------------------------
    // result side: check every taken beat, stall on a pattern of its own
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        mlfr_result_t got;
        int mode;
        int mode_left;
        int hold_left;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                got.out_byte     = result_ch.out_byte;
                got.position     = result_ch.position;
                got.status       = result_ch.status;
                got.frame_length = result_ch.frame_length;
                tracker.check_result(got);
            end
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= 1'($urandom_range(0, 1));
                    2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: result_ch.ready <= ~result_ch.ready;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [BYTE_W-1:0] sum;
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        link_ch.valid     = 1'b0;
        link_ch.data_byte = '0;
        link_ch.channel   = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // noise while hunting, byte extremes
        send_byte(8'h00, 3'd0);
        send_byte(8'hFF, 3'd0);
        // length zero is too short
        send_byte(START_BYTE, 3'd7);
        send_byte(8'h03, 3'd7);
        send_byte(8'h00, 3'd7);
        // too long, and the rejected byte is a start byte
        send_byte(START_BYTE, 3'd7);
        send_byte(8'hFC, 3'd7);
        send_byte(START_BYTE, 3'd7);
        // channel hop restarts the hunt
        send_byte(START_BYTE, 3'd3);
        send_byte(START_BYTE, 3'd5);
        // shortest frame: user data ends at the last header position
        build_frame(8);
        frame_q[6] = 8'hFF;
        frame_q[7] = 8'h00;
        sum = '0;
        for (int i = 6; i < 14; i++)
            sum = sum + frame_q[i];
        frame_q[14] = sum;
        send_frame(3'd7, -1);

        // tightest limit
        write_max_length(8);
        run_random(200);

        // widest limit
        write_max_length(16383);
        run_random(250);

        // receiver holds off while the sender keeps offering
        write_max_length($urandom_range(9, 300));
        hold_request = 1'b1;
        nogap        = 1'b1;
        run_random(150);
        nogap = 1'b0;
        run_random(150);

        // sender pauses until the result side has caught up
        drain();
        run_random(100);

        write_max_length($urandom_range(8, 16383));
        run_random(200);

        write_max_length(MAX_LENGTH_RST);
        run_random(150);

        drain();
        repeat (8) @(posedge clk);
        if (tracker.pending() != 0)
        begin
            $error("%0d result beats never arrived", tracker.pending());
            tracker.error_count++;
        end
        if (tracker.error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin : watchdog
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
